### hdl/u8250_pkg.sv
// ----------------------------------------------------------------------------
// u8250_pkg
// Shared types and constants for the 8250 UART register model.
// ----------------------------------------------------------------------------
package u8250_pkg;

   localparam int RX_DEPTH_DEFAULT = 64;

   // word opcodes
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_HOST_RX = 2'd2;

   // register offsets
   localparam logic [2:0] REG_DATA = 3'd0;  // RBR / THR / DLL
   localparam logic [2:0] REG_IER  = 3'd1;  // IER / DLM
   localparam logic [2:0] REG_IIR  = 3'd2;  // IIR read, FCR write
   localparam logic [2:0] REG_LCR  = 3'd3;
   localparam logic [2:0] REG_MCR  = 3'd4;
   localparam logic [2:0] REG_LSR  = 3'd5;
   localparam logic [2:0] REG_MSR  = 3'd6;
   localparam logic [2:0] REG_SCR  = 3'd7;

   localparam int IER_W = 4;

   // bit positions and fixed values
   localparam int LCR_DLAB_BIT   = 7;
   localparam int MCR_LOOP_BIT   = 4;
   localparam int LSR_DR_BIT     = 0;
   localparam int LSR_THRE_BIT   = 5;
   localparam int LSR_TEMT_BIT   = 6;
   localparam int IER_RDI_BIT    = 0;
   localparam int IER_THRI_BIT   = 1;
   localparam int FCR_CLR_RX_BIT = 1;
   localparam int FCR_CLR_TX_BIT = 2;

   localparam logic [7:0] IIR_NONE   = 8'h01;
   localparam logic [7:0] IIR_THRI   = 8'h02;
   localparam logic [7:0] IIR_RDI    = 8'h04;
   localparam logic [7:0] IIR_TOP    = 8'hC0;
   localparam logic [7:0] MSR_FIXED  = 8'hB0;
   localparam logic [7:0] IER_MASK   = 8'h0F;
   localparam logic [7:0] MCR_RESET  = 8'h08;
   localparam logic [7:0] LSR_RESET  = 8'h60;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] host_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       host_accepted;
   } rsp_type;

endpackage

### hdl/u8250_ram.sv
// ----------------------------------------------------------------------------
// u8250_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u8250_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/uart_8250_register_model_core.sv
// ----------------------------------------------------------------------------
// uart_8250_register_model_core
// 8250 UART register model: guest register access, host receive bytes.
// ----------------------------------------------------------------------------
// The block takes one word per clock while req_ready is high and returns one
// result word per word, in order. A word accepted into the input register is
// decoded there and applied to the register file once the output register is
// free or being taken; its result is then held in the output register.
// While a result waits, the input register still takes one
// word, and then req_ready drops until the result is taken.
// The receive buffer sits in a RAM with registered read; the byte at the
// read index is fetched ahead from the next read index (with a bypass when it
// was just written), which lets a receive read return it without waiting.
// The buffer needs no clearing after reset: only written entries are read.
module uart_8250_register_model_core
   import u8250_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int CNT_W = $clog2(RX_DEPTH + 1);

   // input and output stages
   req_type req_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    fire;

   // register file
   logic [7:0]       dll_ff, dll_in;
   logic [7:0]       dlm_ff, dlm_in;
   logic [IER_W-1:0] ier_ff, ier_in;
   logic [7:0]       fcr_ff, fcr_in;
   logic [7:0]       lcr_ff, lcr_in;
   logic [7:0]       mcr_ff, mcr_in;
   logic [7:0]       lsr_ff, lsr_in;
   logic [7:0]       scr_ff, scr_in;
   logic [7:0]       iir_ff, iir_in;
   logic [CNT_W-1:0] rx_cnt_ff, rx_cnt_in;
   logic [IDX_W-1:0] rx_idx_ff, rx_idx_in;

   // receive RAM and head-byte bypass
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic [7:0]       ram_rdata;
   logic             byp_ff, byp_in;
   logic [7:0]       byp_data_ff;
   logic [7:0]       rx_head;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rx_head   = byp_ff ? byp_data_ff : ram_rdata;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register update for the word in the input stage
   always_comb begin
      logic             dlab;
      logic             loop;
      logic [CNT_W-1:0] idx_next;
      logic [7:0]       pend;

      dll_in    = dll_ff;
      dlm_in    = dlm_ff;
      ier_in    = ier_ff;
      fcr_in    = fcr_ff;
      lcr_in    = lcr_ff;
      mcr_in    = mcr_ff;
      lsr_in    = lsr_ff;
      scr_in    = scr_ff;
      iir_in    = iir_ff;
      rx_cnt_in = rx_cnt_ff;
      rx_idx_in = rx_idx_ff;
      rsp_in    = '0;
      ram_we    = 1'b0;
      ram_waddr = rx_cnt_ff[IDX_W-1:0];
      ram_wdata = req_ff.write_data;
      dlab      = lcr_ff[LCR_DLAB_BIT];
      loop      = mcr_ff[MCR_LOOP_BIT];
      idx_next  = CNT_W'(rx_idx_ff) + CNT_W'(1);
      pend      = '0;

      if (fire) begin
         case (req_ff.opcode)
            OP_READ: begin
               unique case (req_ff.reg_offset)
                  REG_DATA: begin
                     if (dlab) begin
                        rsp_in.read_data = dll_ff;
                     end else if (CNT_W'(rx_idx_ff) < rx_cnt_ff) begin
                        rsp_in.read_data = rx_head;
                        if (idx_next == rx_cnt_ff) begin
                           lsr_in[LSR_DR_BIT] = 1'b0;
                           rx_cnt_in = '0;
                           rx_idx_in = '0;
                        end else begin
                           rx_idx_in = idx_next[IDX_W-1:0];
                        end
                     end
                  end
                  REG_IER: rsp_in.read_data = dlab ? dlm_ff : {{(8-IER_W){1'b0}}, ier_ff};
                  REG_IIR: rsp_in.read_data = iir_ff | IIR_TOP;
                  REG_LCR: rsp_in.read_data = lcr_ff;
                  REG_MCR: rsp_in.read_data = mcr_ff;
                  REG_LSR: rsp_in.read_data = lsr_ff;
                  REG_MSR: rsp_in.read_data = MSR_FIXED;
                  REG_SCR: rsp_in.read_data = scr_ff;
                  default: rsp_in.read_data = '0;
               endcase
            end
            OP_WRITE: begin
               unique case (req_ff.reg_offset)
                  REG_DATA: begin
                     if (dlab) begin
                        dll_in = req_ff.write_data;
                     end else if (loop) begin
                        // loopback byte is dropped on a full buffer
                        if (rx_cnt_ff < CNT_W'(RX_DEPTH)) begin
                           ram_we             = 1'b1;
                           rx_cnt_in          = rx_cnt_ff + CNT_W'(1);
                           lsr_in[LSR_DR_BIT] = 1'b1;
                        end
                     end else begin
                        rsp_in.tx_valid      = 1'b1;
                        rsp_in.tx_byte       = req_ff.write_data;
                        lsr_in[LSR_TEMT_BIT] = 1'b1;
                        lsr_in[LSR_THRE_BIT] = 1'b1;
                     end
                  end
                  REG_IER: begin
                     if (dlab) begin
                        dlm_in = req_ff.write_data;
                     end else begin
                        ier_in = IER_W'(req_ff.write_data & IER_MASK);
                     end
                  end
                  REG_IIR: fcr_in = req_ff.write_data;
                  REG_LCR: lcr_in = req_ff.write_data;
                  REG_MCR: mcr_in = req_ff.write_data;
                  REG_SCR: scr_in = req_ff.write_data;
                  default: ;
               endcase
            end
            OP_HOST_RX: begin
               // refused during loopback, mid-batch or when full
               if (!loop && rx_idx_ff == '0 && rx_cnt_ff < CNT_W'(RX_DEPTH)) begin
                  ram_we               = 1'b1;
                  ram_wdata            = req_ff.host_byte;
                  rx_cnt_in            = rx_cnt_ff + CNT_W'(1);
                  lsr_in[LSR_DR_BIT]   = 1'b1;
                  rsp_in.host_accepted = 1'b1;
               end
            end
            default: ;
         endcase

         // FCR clear bits act once and self-clear
         if (fcr_in[FCR_CLR_RX_BIT]) begin
            fcr_in[FCR_CLR_RX_BIT] = 1'b0;
            rx_cnt_in              = '0;
            rx_idx_in              = '0;
            lsr_in[LSR_DR_BIT]     = 1'b0;
         end
         if (fcr_in[FCR_CLR_TX_BIT]) begin
            fcr_in[FCR_CLR_TX_BIT] = 1'b0;
            lsr_in[LSR_TEMT_BIT]   = 1'b1;
            lsr_in[LSR_THRE_BIT]   = 1'b1;
         end
         if (ier_in[IER_RDI_BIT] && lsr_in[LSR_DR_BIT]) begin
            pend = pend | IIR_RDI;
         end
         if (ier_in[IER_THRI_BIT] && lsr_in[LSR_TEMT_BIT]) begin
            pend = pend | IIR_THRI;
         end
         iir_in          = (pend != '0) ? pend : IIR_NONE;
         rsp_in.irq_line = (pend != '0);
         if (!ier_in[IER_THRI_BIT]) begin
            lsr_in[LSR_TEMT_BIT] = 1'b1;
            lsr_in[LSR_THRE_BIT] = 1'b1;
         end
      end
   end

   // a byte written where the next head is read comes through the bypass
   assign byp_in = ram_we && (ram_waddr == rx_idx_in);

   u8250_ram #(
      .WIDTH(8),
      .DEPTH(RX_DEPTH)
   ) u_rx_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(rx_idx_in),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         dll_ff       <= '0;
         dlm_ff       <= '0;
         ier_ff       <= '0;
         fcr_ff       <= '0;
         lcr_ff       <= '0;
         mcr_ff       <= MCR_RESET;
         lsr_ff       <= LSR_RESET;
         scr_ff       <= '0;
         iir_ff       <= IIR_NONE;
         rx_cnt_ff    <= '0;
         rx_idx_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_ff       <= byp_in;
         dll_ff       <= dll_in;
         dlm_ff       <= dlm_in;
         ier_ff       <= ier_in;
         fcr_ff       <= fcr_in;
         lcr_ff       <= lcr_in;
         mcr_ff       <= mcr_in;
         lsr_ff       <= lsr_in;
         scr_ff       <= scr_in;
         iir_ff       <= iir_in;
         rx_cnt_ff    <= rx_cnt_in;
         rx_idx_ff    <= rx_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
      byp_data_ff <= ram_wdata;
   end

endmodule
